@@ src/fsa_pkg.sv @@
// Shared types, constants and helpers of the fragmented sparse array.
// Used by the controller, the datapath and the top level; depends on nothing.
package fsa_pkg;

   // Port field widths
   localparam int ACTION_W      = 3;
   localparam int INDEX_W       = 8;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int EVENT_W       = 2;
   localparam int USED_OUT_W    = 9;
   localparam int ACTIVE_OUT_W  = 5;
   localparam int ALLOC_OUT_W   = 9;
   localparam int GEOM_W        = 5;
   localparam int CSR_INDEX_W   = 2;

   // Array geometry defaults and key width
   localparam int MAX_FRAGMENTS_DEF = 16;
   localparam int MAX_CELLS_DEF     = 16;
   localparam int KEY_BITS          = 32;
   localparam int KEY_W             = (KEY_BITS < VALUE_W) ? KEY_BITS : VALUE_W;

   localparam logic [GEOM_W-1:0]  GEOM_RESET   = 5'd16;
   localparam logic [VALUE_W-1:0] MARKER_RESET = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAGMENTS = 2'd0,
      CSR_CELLS     = 2'd1,
      CSR_MARKER    = 2'd2
   } fsa_csr_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SET      = 3'd0,
      ACT_GET      = 3'd1,
      ACT_DELETE   = 3'd2,
      ACT_CONTAINS = 3'd3,
      ACT_IS_SET   = 3'd4,
      ACT_CLEAR    = 3'd5
   } fsa_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_ERROR   = 2'd1,
      STAT_NOT_SET = 2'd2
   } fsa_status_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_ALLOC = 2'd1,
      EV_FREE  = 2'd2
   } fsa_event_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_DECODE,
      S_FILL,
      S_READ,
      S_EXEC,
      S_SCAN,
      S_DONE
   } fsa_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic div_step;
      logic mark_error;
      logic fill_write;
      logic fill_end;
      logic exec;
      logic scan_step;
      logic clear_all;
      logic result_load;
   } fsa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                div_last;
      logic                in_range;
      logic                key_is_marker;
      logic                frag_alloc;
      logic                fill_last;
      logic                scan_hit;
      logic                scan_over;
   } fsa_sts_type;

   // Zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v,
                                                    input int max_v);
      logic [GEOM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = GEOM_W'(1);
      end else if (int'(v) > max_v) begin
         r = GEOM_W'(max_v);
      end
      return r;
   endfunction

endpackage

@@ src/fsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fsa_ctrl.sv @@
// Sequencing state machine of the fragmented sparse array.
// Depends on fsa_pkg; drives datapath commands and the request/response handshakes.
module fsa_ctrl import fsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  fsa_sts_type sts,
   output fsa_cmd_type cmd
);

   fsa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.action)
               ACT_SET: begin
                  if (!sts.in_range || sts.key_is_marker) begin
                     cmd.mark_error = 1'b1;
                     state_in       = S_DONE;
                  end else if (!sts.frag_alloc) begin
                     state_in = S_FILL;
                  end else begin
                     state_in = S_READ;
                  end
               end
               ACT_GET, ACT_DELETE, ACT_IS_SET: begin
                  if (!sts.in_range) begin
                     cmd.mark_error = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               ACT_CONTAINS: begin
                  state_in = S_SCAN;
               end
               ACT_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FILL: begin
            // write the marker into every cell of the new fragment
            cmd.fill_write = 1'b1;
            if (sts.fill_last) begin
               cmd.fill_end = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit || sts.scan_over) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_fill_unallocated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> !sts.frag_alloc)
      else $error("fill running on an allocated fragment");

   a_exec_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> ($past(state_ff) == S_READ))
      else $error("execute without a settled RAM read");

endmodule

@@ src/fsa_datapath.sv @@
// Datapath of the fragmented sparse array: config registers, index divider,
// cell and count RAMs, allocation map, counters and response register.
// Depends on fsa_pkg and fsa_ram.
module fsa_datapath import fsa_pkg::*; #(
   parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
   parameter int MAX_CELLS     = MAX_CELLS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [INDEX_W-1:0]         req_cell_index,
   input  logic signed [VALUE_W-1:0]  req_key_value,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [VALUE_W-1:0]         csr_wdata,
   input  fsa_cmd_type                cmd,
   output fsa_sts_type                sts,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic                       rsp_found,
   output logic [EVENT_W-1:0]         rsp_fragment_event,
   output logic [USED_OUT_W-1:0]      rsp_used_cells,
   output logic [ACTIVE_OUT_W-1:0]    rsp_active_fragments,
   output logic [ALLOC_OUT_W-1:0]     rsp_allocated_cells
);

   localparam int FRAG_W     = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int OFF_W      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int DEPTH      = MAX_FRAGMENTS * MAX_CELLS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NF_W       = $clog2(MAX_FRAGMENTS + 1);
   localparam int CNT_W      = $clog2(MAX_CELLS + 1);
   localparam int USED_W     = $clog2(DEPTH + 1);
   localparam int DIV_CNT_W  = $clog2(INDEX_W);
   // wide enough for the quotient, the geometry and the walk counters
   localparam int CMP_W      = INDEX_W + 1;
   localparam int PROD_W     = NF_W + GEOM_W;
   localparam int PROD_PAD_W = PROD_W + ALLOC_OUT_W;
   localparam int USED_PAD_W = USED_W + USED_OUT_W;
   localparam int ACT_PAD_W  = NF_W + ACTIVE_OUT_W;

   // Configuration
   logic [GEOM_W-1:0]  frags_cfg_ff, frags_cfg_in;
   logic [GEOM_W-1:0]  cells_cfg_ff, cells_cfg_in;
   logic [VALUE_W-1:0] marker_ff, marker_in;
   logic [GEOM_W-1:0]  nf, cf;
   logic [KEY_W-1:0]   marker_k;

   // Request and divider
   logic [ACTION_W-1:0]  action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [INDEX_W-1:0]   quo_ff, quo_in;
   logic [GEOM_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [GEOM_W:0]      trial;
   logic                 trial_ge;
   logic [GEOM_W:0]      trial_diff;

   // Walk counters for fill and scan
   logic [OFF_W-1:0] walk_off_ff, walk_off_in;
   logic [NF_W-1:0]  scan_f_ff, scan_f_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             off_last, scan_live, scan_alloc, scan_hit;

   // Array state
   logic [MAX_FRAGMENTS-1:0] alloc_ff, alloc_in;
   logic [USED_W-1:0]        used_ff, used_in;
   logic [NF_W-1:0]          active_ff, active_in;

   // Working result
   fsa_status_type     status_ff, status_in;
   logic [VALUE_W-1:0] rd_ff, rd_in;
   logic               found_ff, found_in;
   fsa_event_type      event_ff, event_in;

   // Response register
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]      rsp_rd_ff, rsp_rd_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [EVENT_W-1:0]      rsp_event_ff, rsp_event_in;
   logic [USED_OUT_W-1:0]   rsp_used_ff, rsp_used_in;
   logic [ACTIVE_OUT_W-1:0] rsp_active_ff, rsp_active_in;
   logic [ALLOC_OUT_W-1:0]  rsp_alloc_ff, rsp_alloc_in;

   // Addressing
   logic [FRAG_W-1:0] frag;
   logic [OFF_W-1:0]  off;
   logic [ADDR_W-1:0] frag_base, slot_addr, fill_addr, scan_addr;
   logic              frag_alloc, in_range;

   // RAM ports
   logic              cell_we;
   logic [ADDR_W-1:0] cell_wr_addr, cell_rd_addr;
   logic [KEY_W-1:0]  cell_wdata, cell_rdata;
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_cur;
   logic              cell_unused;

   logic [PROD_W-1:0]     alloc_prod;
   logic [PROD_PAD_W-1:0] alloc_pad;
   logic [USED_PAD_W-1:0] used_pad;
   logic [ACT_PAD_W-1:0]  active_pad;

   assign nf       = clamp_geom(frags_cfg_ff, MAX_FRAGMENTS);
   assign cf       = clamp_geom(cells_cfg_ff, MAX_CELLS);
   assign marker_k = marker_ff[KEY_W-1:0];

   // One quotient bit per step, restoring
   assign trial      = {rem_ff, quo_ff[INDEX_W-1]};
   assign trial_ge   = (trial >= {1'b0, cf});
   assign trial_diff = trial - {1'b0, cf};

   assign frag      = FRAG_W'(quo_ff);
   assign off       = OFF_W'(rem_ff);
   assign in_range  = (CMP_W'(quo_ff) < CMP_W'(nf));
   assign frag_alloc = alloc_ff[frag];
   assign frag_base = ADDR_W'(frag) * ADDR_W'(MAX_CELLS);
   assign slot_addr = frag_base + ADDR_W'(off);
   assign fill_addr = frag_base + ADDR_W'(walk_off_ff);
   assign scan_addr = ADDR_W'(FRAG_W'(scan_f_ff)) * ADDR_W'(MAX_CELLS)
                      + ADDR_W'(walk_off_ff);

   assign off_last   = ((CMP_W'(walk_off_ff) + CMP_W'(1)) == CMP_W'(cf));
   assign scan_live  = (CMP_W'(scan_f_ff) < CMP_W'(nf));
   assign scan_alloc = alloc_ff[FRAG_W'(scan_f_ff)];
   assign scan_hit   = cmp_valid_ff && (cell_rdata == key_ff);

   assign cell_unused = (cell_rdata == marker_k);
   assign cnt_cur     = frag_alloc ? cnt_rdata : '0;

   assign alloc_prod = PROD_W'(active_ff) * PROD_W'(cf);
   assign alloc_pad  = PROD_PAD_W'(alloc_prod);
   assign used_pad   = USED_PAD_W'(used_ff);
   assign active_pad = ACT_PAD_W'(active_ff);

   fsa_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wdata),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rdata)
   );

   fsa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_FRAGMENTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (frag),
      .wr_data (cnt_wdata),
      .rd_addr (frag),
      .rd_data (cnt_rdata)
   );

   always_comb begin
      frags_cfg_in  = frags_cfg_ff;
      cells_cfg_in  = cells_cfg_ff;
      marker_in     = marker_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      walk_off_in   = walk_off_ff;
      scan_f_in     = scan_f_ff;
      cmp_valid_in  = cmp_valid_ff;
      alloc_in      = alloc_ff;
      used_in       = used_ff;
      active_in     = active_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      found_in      = found_ff;
      event_in      = event_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_active_in = rsp_active_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      cell_we       = 1'b0;
      cell_wr_addr  = slot_addr;
      cell_rd_addr  = slot_addr;
      cell_wdata    = key_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;

      if (cmd.load_req) begin
         action_in    = req_action;
         key_in       = req_key_value[KEY_W-1:0];
         quo_in       = req_cell_index;
         rem_in       = '0;
         div_cnt_in   = '0;
         walk_off_in  = '0;
         scan_f_in    = '0;
         cmp_valid_in = 1'b0;
         status_in    = STAT_OK;
         rd_in        = '0;
         found_in     = 1'b0;
         event_in     = EV_NONE;
      end

      if (cmd.div_step) begin
         quo_in     = {quo_ff[INDEX_W-2:0], trial_ge};
         rem_in     = trial_ge ? trial_diff[GEOM_W-1:0] : trial[GEOM_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.mark_error) begin
         status_in = STAT_ERROR;
      end

      if (cmd.fill_write) begin
         cell_we      = 1'b1;
         cell_wr_addr = fill_addr;
         cell_wdata   = marker_k;
         walk_off_in  = walk_off_ff + OFF_W'(1);
      end

      if (cmd.fill_end) begin
         alloc_in[frag] = 1'b1;
         active_in      = active_ff + NF_W'(1);
         event_in       = EV_ALLOC;
         cnt_we         = 1'b1;
         cnt_wdata      = '0;
      end

      if (cmd.exec) begin
         case (action_ff)
            ACT_SET: begin
               cell_we    = 1'b1;
               cell_wdata = key_ff;
               if (cell_unused) begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_cur + CNT_W'(1);
                  used_in   = used_ff + USED_W'(1);
               end
            end
            ACT_GET: begin
               rd_in = frag_alloc ? VALUE_W'(cell_rdata) : VALUE_W'(marker_k);
            end
            ACT_DELETE: begin
               if (!frag_alloc || cell_unused) begin
                  status_in = STAT_NOT_SET;
               end else begin
                  cell_we    = 1'b1;
                  cell_wdata = marker_k;
                  cnt_we     = 1'b1;
                  cnt_wdata  = cnt_cur - CNT_W'(1);
                  used_in    = used_ff - USED_W'(1);
                  // last used cell gone: free the fragment
                  if (cnt_cur == CNT_W'(1)) begin
                     alloc_in[frag] = 1'b0;
                     active_in      = active_ff - NF_W'(1);
                     event_in       = EV_FREE;
                  end
               end
            end
            ACT_IS_SET: begin
               found_in = frag_alloc && !cell_unused;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_step) begin
         cell_rd_addr = scan_addr;
         cmp_valid_in = scan_live && scan_alloc;
         if (scan_hit) begin
            found_in = 1'b1;
         end
         // skip unallocated fragments, walk cells of allocated ones
         if (scan_live) begin
            if (!scan_alloc || off_last) begin
               scan_f_in   = scan_f_ff + NF_W'(1);
               walk_off_in = '0;
            end else begin
               walk_off_in = walk_off_ff + OFF_W'(1);
            end
         end
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_FRAGMENTS: frags_cfg_in = csr_wdata[GEOM_W-1:0];
            CSR_CELLS:     cells_cfg_in = csr_wdata[GEOM_W-1:0];
            CSR_MARKER:    marker_in    = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.clear_all || (csr_valid && (csr_index == CSR_FRAGMENTS
          || csr_index == CSR_CELLS || csr_index == CSR_MARKER))) begin
         alloc_in  = '0;
         used_in   = '0;
         active_in = '0;
      end

      if (cmd.result_load) begin
         rsp_status_in = status_ff;
         rsp_rd_in     = rd_ff;
         rsp_found_in  = found_ff;
         rsp_event_in  = event_ff;
         rsp_used_in   = used_pad[USED_OUT_W-1:0];
         rsp_active_in = active_pad[ACTIVE_OUT_W-1:0];
         rsp_alloc_in  = alloc_pad[ALLOC_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frags_cfg_ff <= GEOM_RESET;
         cells_cfg_ff <= GEOM_RESET;
         marker_ff    <= MARKER_RESET;
         alloc_ff     <= '0;
         used_ff      <= '0;
         active_ff    <= '0;
         div_cnt_ff   <= '0;
         walk_off_ff  <= '0;
         scan_f_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         frags_cfg_ff <= frags_cfg_in;
         cells_cfg_ff <= cells_cfg_in;
         marker_ff    <= marker_in;
         alloc_ff     <= alloc_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         div_cnt_ff   <= div_cnt_in;
         walk_off_ff  <= walk_off_in;
         scan_f_ff    <= scan_f_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      found_ff      <= found_in;
      event_ff      <= event_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_active_ff <= rsp_active_in;
      rsp_alloc_ff  <= rsp_alloc_in;
   end

   always_comb begin
      sts               = '0;
      sts.action        = action_ff;
      sts.div_last      = (div_cnt_ff == DIV_CNT_W'(INDEX_W - 1));
      sts.in_range      = in_range;
      sts.key_is_marker = (key_ff == marker_k);
      sts.frag_alloc    = frag_alloc;
      sts.fill_last     = off_last;
      sts.scan_hit      = scan_hit;
      sts.scan_over     = !scan_live && !cmp_valid_ff;
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_read_value       = rsp_rd_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_fragment_event   = rsp_event_ff;
   assign rsp_used_cells       = rsp_used_ff;
   assign rsp_active_fragments = rsp_active_ff;
   assign rsp_allocated_cells  = rsp_alloc_ff;

   a_active_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(alloc_ff) == int'(active_ff))
      else $error("active fragment count differs from allocation map");

   a_used_within_alloc: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= int'(active_ff) * int'(cf))
      else $error("used cells exceed allocated cells");

endmodule

@@ src/fragmented_sparse_array.sv @@
// Fragmented sparse array top level. Each request runs through the 8-step divider,
// then decode. Get, delete, is-set and set read and execute one cell; a set that
// allocates first fills the new fragment with the marker. Errors and clear-all
// go straight to the response; contains walks the cells of allocated fragments and
// skips unallocated ones until a hit or the end. req_ready returns with rsp_valid.
// Reset clears the allocation map and counters at once; cell storage is not cleared.
module fragmented_sparse_array import fsa_pkg::*; #(
   parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
   parameter int MAX_CELLS     = MAX_CELLS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [INDEX_W-1:0]         req_cell_index,
   input  logic signed [VALUE_W-1:0]  req_key_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic                       rsp_found,
   output logic [EVENT_W-1:0]         rsp_fragment_event,
   output logic [USED_OUT_W-1:0]      rsp_used_cells,
   output logic [ACTIVE_OUT_W-1:0]    rsp_active_fragments,
   output logic [ALLOC_OUT_W-1:0]     rsp_allocated_cells,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [VALUE_W-1:0]         csr_wdata
);

   fsa_cmd_type cmd;
   fsa_sts_type sts;

   // register writes are always accepted and registered
   assign csr_ready = 1'b1;

   fsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsa_datapath #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS),
      .MAX_CELLS     (MAX_CELLS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_action           (req_action),
      .req_cell_index       (req_cell_index),
      .req_key_value        (req_key_value),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_status           (rsp_status),
      .rsp_read_value       (rsp_read_value),
      .rsp_found            (rsp_found),
      .rsp_fragment_event   (rsp_fragment_event),
      .rsp_used_cells       (rsp_used_cells),
      .rsp_active_fragments (rsp_active_fragments),
      .rsp_allocated_cells  (rsp_allocated_cells)
   );

endmodule
